[src/wpsd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the twiddle function of the Welch PSD estimator.
package wpsd_pkg;

    // Build-time segment length default
    localparam int SEG_LEN_DEF = 64;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int COEF_IDX_W = 6;
    localparam int COEF_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int BIN_W      = 6;
    localparam int POWER_W    = 48;
    localparam int ACC_W      = 64;
    localparam int SEGCNT_W   = 24;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Internal arithmetic widths
    localparam int Y_W     = 27;  // windowed sample, Q.8
    localparam int COS_W   = 17;  // twiddle, Q1.15 with sign
    localparam int RI_W    = 29;  // rounded Re/Im, Q.4
    localparam int PH_W    = 6;   // twiddle table phase
    localparam int RI_SH   = 19;  // Re/Im rounding shift
    localparam int WIN_SH0 = 7;   // window shift on top of log2(SEG_LEN)

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_COEF   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_HALF  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SCALE = 1'd1;

    localparam logic             RST_OVERLAP_HALF = 1'b1;
    localparam logic [SCALE_W-1:0] RST_DENSITY_SCALE = 32'd65536;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_LAST,
        ST_DFT,
        ST_DRAIN,
        ST_SQUARE,
        ST_ACC,
        ST_FIN_RD,
        ST_FIN_LD,
        ST_FIN_DIV,
        ST_FIN_MUL,
        ST_FIN_SCALE,
        ST_FIN_OUT
    } t_state;

    // First quarter of a 64-point cosine, Q1.15
    localparam logic signed [COS_W-1:0] QUARTER_COS [17] = '{
        17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30273, 17'sd28899,
        17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
        17'sd12540, 17'sd9512,  17'sd6393,  17'sd3212,  17'sd0
    };

    // Full-period cosine from the quarter table
    function automatic logic signed [COS_W-1:0] cos64(input logic [PH_W-1:0] m);
        logic [4:0] idx;
        logic       neg;
        if (m <= 6'd16) begin
            idx = 5'(m);
            neg = 1'b0;
        end else if (m <= 6'd32) begin
            idx = 5'(6'd32 - m);
            neg = 1'b1;
        end else if (m <= 6'd48) begin
            idx = 5'(m - 6'd32);
            neg = 1'b1;
        end else begin
            idx = 5'(7'd64 - {1'b0, m});
            neg = 1'b0;
        end
        return neg ? -QUARTER_COS[idx] : QUARTER_COS[idx];
    endfunction

endpackage

[src/wpsd_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for bin averaging.
module wpsd_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [wpsd_pkg::ACC_W-1:0]       i_dividend,
    input  logic [wpsd_pkg::SEGCNT_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [wpsd_pkg::ACC_W-1:0]       o_quotient
);
    localparam int DW  = wpsd_pkg::ACC_W;
    localparam int VW  = wpsd_pkg::SEGCNT_W;
    localparam int CNW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNW-1:0]  r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_den;
    logic [VW:0]     trial;
    logic            fits;

    // Trial subtract of the next partial remainder
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        fits  = trial >= {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? VW'(trial - {1'b0, r_den}) : VW'(trial);
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/welch_psd_estimator.sv]
`timescale 1ns / 1ps
// Welch PSD estimator top level: segment buffer, windowed DFT, bin accumulators, readout.
//
// Coefficient and sample requests are taken whenever the block is idle. When a
// sample completes a segment (every SEG_LEN/2 samples with overlap_half set,
// every SEG_LEN otherwise) the block stalls its input while it makes one pass over
// the sample memory for the mean, then for each bin one pass through a single
// complex multiply-accumulate unit fed from the sample and window memories,
// followed by a read-modify-write of that bin's accumulator. A finish request
// emits SEG_LEN/2+1 bins, each one waiting on the 64-step serial divider and on
// any output stall; input is held off until the last bin is taken. Configuration
// writes are accepted every cycle and must only be issued while the block is idle.
module welch_psd_estimator #(
    parameter int SEG_LEN = wpsd_pkg::SEG_LEN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input requests
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [wpsd_pkg::KIND_W-1:0]          i_kind,
    input  logic [wpsd_pkg::COEF_IDX_W-1:0]      i_coef_index,
    input  logic [wpsd_pkg::COEF_W-1:0]          i_coef_value,
    input  logic signed [wpsd_pkg::SAMPLE_W-1:0] i_sample_value,
    // Result requests
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [wpsd_pkg::BIN_W-1:0]           o_bin_index,
    output logic [wpsd_pkg::POWER_W-1:0]         o_power,
    output logic                                 o_no_segments,
    output logic                                 o_last_bin,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wpsd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wpsd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int AW    = $clog2(SEG_LEN);
    localparam int NBIN  = SEG_LEN / 2 + 1;
    localparam int KW    = $clog2(NBIN);
    localparam int CW    = $clog2(SEG_LEN + 1);
    localparam int STEP  = 64 / SEG_LEN;
    localparam int SW    = wpsd_pkg::SAMPLE_W;
    localparam int S_W   = SW + AW;          // segment sum
    localparam int E_W   = S_W + 1;          // detrended sample
    localparam int P_W   = E_W + 17;         // detrended times window
    localparam int Y_SH  = AW + wpsd_pkg::WIN_SH0;
    localparam int Y_W   = wpsd_pkg::Y_W;
    localparam int C_W   = wpsd_pkg::COS_W;
    localparam int PR_W  = Y_W + C_W;        // one twiddle product
    localparam int RE_W  = PR_W + AW + 1;    // Re/Im accumulator
    localparam int RI_W  = wpsd_pkg::RI_W;
    localparam int SQ_W  = 2 * RI_W;
    localparam int AC_W  = wpsd_pkg::ACC_W;
    localparam int PH_W  = wpsd_pkg::PH_W;
    localparam int PW    = wpsd_pkg::POWER_W;
    localparam int SC_W  = wpsd_pkg::SCALE_W;
    localparam int NC_W  = wpsd_pkg::SEGCNT_W;

    wpsd_pkg::t_state r_state, n_state;

    // Configuration registers
    logic              r_overlap;
    logic [SC_W-1:0]   r_scale;

    // Memories and read data
    logic [wpsd_pkg::COEF_W-1:0] r_win_mem  [SEG_LEN];
    logic signed [SW-1:0]        r_ring_mem [SEG_LEN];
    logic [AC_W-1:0]             r_acc_mem  [NBIN];
    logic [wpsd_pkg::COEF_W-1:0] r_win_q;
    logic signed [SW-1:0]        r_ring_q;
    logic [AC_W-1:0]             r_acc_q;
    logic [NBIN-1:0]             r_acc_vld;

    // Segment bookkeeping
    logic [AW-1:0]    r_wp;
    logic [CW-1:0]    r_seen;
    logic [CW-1:0]    r_hop;
    logic [NC_W-1:0]  r_segs;

    // Sequencing
    logic [AW-1:0]    r_i;
    logic [KW-1:0]    r_k;
    logic [PH_W-1:0]  r_kstep;
    logic [PH_W-1:0]  r_ph;
    logic             r_sv;

    // MAC pipeline
    logic signed [S_W-1:0]  r_sum;
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic [PH_W-1:0]        r_m1, r_m2, r_m3;
    logic signed [P_W-1:0]  r_prod;
    logic signed [Y_W-1:0]  r_y;
    logic signed [PR_W-1:0] r_pre, r_pim;
    logic signed [RE_W-1:0] r_re, r_im;
    logic signed [RI_W-1:0] r_re_r, r_im_r;
    logic signed [SQ_W-1:0] r_sq_re, r_sq_im;

    localparam int BIN_W_L = wpsd_pkg::BIN_W;

    // Readout
    logic              div_start;
    logic              div_done;
    logic [AC_W-1:0]   div_quo;
    logic [AC_W-1:0]   r_lo, r_hi;
    logic              r_ovalid;
    logic [BIN_W_L-1:0] r_obin;
    logic [PW-1:0]     r_opower;
    logic              r_onoseg;
    logic              r_olast;

    // Handshake and decode
    logic              in_acc;
    logic              take_coef, take_sample, take_finish;
    logic              cfg_acc;
    logic [CW-1:0]     seen_n, hop_n, hop_len;
    logic              seg_start;
    logic              pipe_busy;
    logic              k_last;
    logic [AW-1:0]     ring_raddr;
    logic [AC_W-1:0]   acc_cur;

    assign in_acc      = i_valid && !o_stall;
    assign take_coef   = in_acc && (i_kind == wpsd_pkg::KIND_COEF);
    assign take_sample = in_acc && (i_kind == wpsd_pkg::KIND_SAMPLE);
    assign take_finish = in_acc && (i_kind == wpsd_pkg::KIND_FINISH);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != wpsd_pkg::ST_IDLE);

    // Segment trigger on a new sample
    always_comb begin
        seen_n    = (r_seen < CW'(SEG_LEN)) ? r_seen + 1'b1 : r_seen;
        hop_n     = (r_hop < CW'(SEG_LEN)) ? r_hop + 1'b1 : r_hop;
        hop_len   = r_overlap ? CW'(SEG_LEN / 2) : CW'(SEG_LEN);
        seg_start = take_sample && (seen_n == CW'(SEG_LEN)) && (hop_n >= hop_len);
    end

    assign pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
    assign k_last     = (r_k == KW'(SEG_LEN / 2));
    assign ring_raddr = r_wp + r_i;
    assign acc_cur    = r_acc_vld[r_k] ? r_acc_q : '0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap <= wpsd_pkg::RST_OVERLAP_HALF;
            r_scale   <= wpsd_pkg::RST_DENSITY_SCALE;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                wpsd_pkg::CFG_OVERLAP_HALF:  r_overlap <= i_cfg_data[0];
                wpsd_pkg::CFG_DENSITY_SCALE: r_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Window table
    always_ff @(posedge i_clk) begin
        if (take_coef && ({1'b0, i_coef_index} < (wpsd_pkg::COEF_IDX_W + 1)'(SEG_LEN)))
            r_win_mem[AW'(i_coef_index)] <= i_coef_value;
        r_win_q <= r_win_mem[r_i];
    end

    // Sample ring, oldest sample at the write pointer
    always_ff @(posedge i_clk) begin
        if (take_sample)
            r_ring_mem[r_wp] <= i_sample_value;
        r_ring_q <= r_ring_mem[ring_raddr];
    end

    // Bin accumulators
    logic [SQ_W:0]   mag;
    logic [AC_W:0]   acc_sum;
    logic [AC_W-1:0] acc_new;
    always_comb begin
        mag     = {1'b0, $unsigned(r_sq_re)} + {1'b0, $unsigned(r_sq_im)};
        acc_sum = {1'b0, acc_cur} + (AC_W + 1)'(mag);
        acc_new = acc_sum[AC_W] ? {AC_W{1'b1}} : acc_sum[AC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wpsd_pkg::ST_ACC)
            r_acc_mem[r_k] <= acc_new;
        r_acc_q <= r_acc_mem[r_k];
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            wpsd_pkg::ST_IDLE: begin
                if (seg_start)        n_state = wpsd_pkg::ST_SUM;
                else if (take_finish) n_state = wpsd_pkg::ST_FIN_RD;
            end
            wpsd_pkg::ST_SUM:
                if (r_i == AW'(SEG_LEN - 1)) n_state = wpsd_pkg::ST_SUM_LAST;
            wpsd_pkg::ST_SUM_LAST: n_state = wpsd_pkg::ST_DFT;
            wpsd_pkg::ST_DFT:
                if (r_i == AW'(SEG_LEN - 1)) n_state = wpsd_pkg::ST_DRAIN;
            wpsd_pkg::ST_DRAIN:
                if (!pipe_busy) n_state = wpsd_pkg::ST_SQUARE;
            wpsd_pkg::ST_SQUARE: n_state = wpsd_pkg::ST_ACC;
            wpsd_pkg::ST_ACC:
                n_state = k_last ? wpsd_pkg::ST_IDLE : wpsd_pkg::ST_DFT;
            wpsd_pkg::ST_FIN_RD: n_state = wpsd_pkg::ST_FIN_LD;
            wpsd_pkg::ST_FIN_LD: begin
                div_start = 1'b1;
                n_state   = wpsd_pkg::ST_FIN_DIV;
            end
            wpsd_pkg::ST_FIN_DIV:
                if (div_done) n_state = wpsd_pkg::ST_FIN_MUL;
            wpsd_pkg::ST_FIN_MUL:   n_state = wpsd_pkg::ST_FIN_SCALE;
            wpsd_pkg::ST_FIN_SCALE: n_state = wpsd_pkg::ST_FIN_OUT;
            wpsd_pkg::ST_FIN_OUT:
                if (!i_stall) n_state = k_last ? wpsd_pkg::ST_IDLE : wpsd_pkg::ST_FIN_RD;
            default: n_state = wpsd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wpsd_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_seen    <= '0;
            r_hop     <= '0;
            r_segs    <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_kstep   <= '0;
            r_ph      <= '0;
            r_sv      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_acc_vld <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_sv <= (r_state == wpsd_pkg::ST_SUM);
            r_v1 <= (r_state == wpsd_pkg::ST_DFT);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            case (r_state)
                wpsd_pkg::ST_IDLE: begin
                    if (take_sample) begin
                        r_wp   <= r_wp + 1'b1;
                        r_seen <= seen_n;
                        r_hop  <= seg_start ? '0 : hop_n;
                    end
                    r_i     <= '0;
                    r_k     <= '0;
                    r_kstep <= '0;
                    r_ph    <= '0;
                end
                wpsd_pkg::ST_SUM: r_i <= r_i + 1'b1;
                wpsd_pkg::ST_SUM_LAST: begin
                    r_i  <= '0;
                    r_ph <= '0;
                end
                wpsd_pkg::ST_DFT: begin
                    r_i  <= r_i + 1'b1;
                    r_ph <= r_ph + r_kstep;
                end
                wpsd_pkg::ST_ACC: begin
                    r_acc_vld[r_k] <= 1'b1;
                    r_i  <= '0;
                    r_ph <= '0;
                    if (k_last) begin
                        if (r_segs != {NC_W{1'b1}}) r_segs <= r_segs + 1'b1;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_kstep <= r_kstep + PH_W'(STEP);
                    end
                end
                wpsd_pkg::ST_FIN_SCALE: r_ovalid <= 1'b1;
                wpsd_pkg::ST_FIN_OUT: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        if (k_last) begin
                            r_acc_vld <= '0;
                            r_segs    <= '0;
                            r_seen    <= '0;
                            r_hop     <= '0;
                            r_k       <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Windowed sample rounding, half away from zero
    logic signed [E_W-1:0] e_val;
    logic [P_W:0]          p_abs, p_rnd;
    logic                  p_neg;
    always_comb begin
        e_val = ($signed({{(E_W - SW){r_ring_q[SW-1]}}, r_ring_q}) <<< AW)
              - $signed({r_sum[S_W-1], r_sum});
        p_neg = r_prod[P_W-1];
        p_abs = p_neg ? (P_W + 1)'(-$signed({r_prod[P_W-1], r_prod}))
                      : (P_W + 1)'($signed({r_prod[P_W-1], r_prod}));
        p_rnd = (p_abs + ((P_W + 1)'(1) << (Y_SH - 1))) >> Y_SH;
    end

    // Re/Im rounding to Q.4
    logic [RE_W:0] re_abs, re_rnd, im_abs, im_rnd;
    always_comb begin
        re_abs = r_re[RE_W-1] ? (RE_W + 1)'(-$signed({r_re[RE_W-1], r_re}))
                              : (RE_W + 1)'($signed({r_re[RE_W-1], r_re}));
        im_abs = r_im[RE_W-1] ? (RE_W + 1)'(-$signed({r_im[RE_W-1], r_im}))
                              : (RE_W + 1)'($signed({r_im[RE_W-1], r_im}));
        re_rnd = (re_abs + ((RE_W + 1)'(1) << (wpsd_pkg::RI_SH - 1))) >> wpsd_pkg::RI_SH;
        im_rnd = (im_abs + ((RE_W + 1)'(1) << (wpsd_pkg::RI_SH - 1))) >> wpsd_pkg::RI_SH;
    end

    // MAC datapath
    always_ff @(posedge i_clk) begin
        // segment sum
        if (r_state == wpsd_pkg::ST_IDLE)
            r_sum <= '0;
        else if (r_sv)
            r_sum <= r_sum + S_W'(r_ring_q);
        // detrend and window
        r_m1   <= r_ph;
        r_m2   <= r_m1;
        r_m3   <= r_m2;
        r_prod <= e_val * $signed({1'b0, r_win_q});
        r_y    <= p_neg ? -$signed(Y_W'(p_rnd)) : $signed(Y_W'(p_rnd));
        // twiddle products
        r_pre  <= r_y * wpsd_pkg::cos64(r_m3);
        r_pim  <= r_y * wpsd_pkg::cos64(r_m3 + PH_W'(48));
        // accumulate one bin
        if (r_state == wpsd_pkg::ST_SUM_LAST || r_state == wpsd_pkg::ST_ACC) begin
            r_re <= '0;
            r_im <= '0;
        end else if (r_v4) begin
            r_re <= r_re + RE_W'(r_pre);
            r_im <= r_im + RE_W'(r_pim);
        end
        if (r_state == wpsd_pkg::ST_DRAIN) begin
            r_re_r <= r_re[RE_W-1] ? -$signed(RI_W'(re_rnd)) : $signed(RI_W'(re_rnd));
            r_im_r <= r_im[RE_W-1] ? -$signed(RI_W'(im_rnd)) : $signed(RI_W'(im_rnd));
        end
        r_sq_re <= r_re_r * r_re_r;
        r_sq_im <= r_im_r * r_im_r;
    end

    // Averaging divider
    wpsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc_cur),
        .i_divisor  (r_segs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Density scaling and one-sided doubling
    logic          edge_bin;
    logic          hi_ovf;
    logic [AC_W+1:0] scaled;
    logic [PW-1:0] power_n;
    always_comb begin
        edge_bin = (r_k == '0) || k_last;
        if (edge_bin) begin
            hi_ovf = (r_hi[AC_W-1:32] != '0);
            scaled = ((AC_W + 2)'(r_hi) << 16) + (AC_W + 2)'(r_lo >> 16);
        end else begin
            hi_ovf = (r_hi[AC_W-1:31] != '0);
            scaled = ((AC_W + 2)'(r_hi) << 17) + (AC_W + 2)'(r_lo >> 15);
        end
        if (r_segs == '0)
            power_n = '0;
        else if (hi_ovf || (scaled[AC_W+1:PW] != '0))
            power_n = {PW{1'b1}};
        else
            power_n = scaled[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wpsd_pkg::ST_FIN_MUL) begin
            r_lo <= AC_W'(div_quo[31:0]) * AC_W'(r_scale);
            r_hi <= AC_W'(div_quo[AC_W-1:32]) * AC_W'(r_scale);
        end
        if (r_state == wpsd_pkg::ST_FIN_SCALE) begin
            r_obin   <= BIN_W_L'(r_k);
            r_opower <= power_n;
            r_onoseg <= (r_segs == '0);
            r_olast  <= k_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_bin_index   = r_obin;
    assign o_power       = r_opower;
    assign o_no_segments = r_onoseg;
    assign o_last_bin    = r_olast;

endmodule

[src/wpsd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the Welch PSD estimator, bound to the top level.
module wpsd_checker #(
    parameter int SEG_LEN = wpsd_pkg::SEG_LEN_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [wpsd_pkg::BIN_W-1:0]    o_bin_index,
    input logic [wpsd_pkg::POWER_W-1:0]  o_power,
    input logic                          o_no_segments,
    input logic                          o_last_bin
);
    // A held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // No input taken during readout
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during readout");

    // Last flag only on the Nyquist bin
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_bin |-> o_bin_index == wpsd_pkg::BIN_W'(SEG_LEN / 2))
        else $error("last flag on wrong bin");

    // Empty spectrum is zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_segments |-> o_power == '0)
        else $error("nonzero power with no segments");

    // Readout ends after the last bin
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_bin && !i_stall |=> !o_valid)
        else $error("result after last bin");

endmodule

bind welch_psd_estimator wpsd_checker #(.SEG_LEN(SEG_LEN)) u_wpsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_bin_index   (o_bin_index),
    .o_power       (o_power),
    .o_no_segments (o_no_segments),
    .o_last_bin    (o_last_bin)
);

[test/welch_psd_estimator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the Welch PSD estimator against an in-bench spectrum model.
module welch_psd_estimator_test;

    localparam int NSEG = wpsd_pkg::SEG_LEN_DEF;
    localparam int NBIN = NSEG / 2 + 1;
    localparam longint unsigned P_MAX = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        wpsd_pkg::t_kind                      kind;
        logic [wpsd_pkg::COEF_IDX_W-1:0]      idx;
        logic [wpsd_pkg::COEF_W-1:0]          coef;
        logic signed [wpsd_pkg::SAMPLE_W-1:0] smp;
    } t_req;

    typedef struct {
        logic [wpsd_pkg::BIN_W-1:0]   bin;
        logic [wpsd_pkg::POWER_W-1:0] power;
        logic                         noseg;
        logic                         last;
    } t_bin;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic [wpsd_pkg::KIND_W-1:0] i_kind;
    logic [wpsd_pkg::COEF_IDX_W-1:0] i_coef_index;
    logic [wpsd_pkg::COEF_W-1:0] i_coef_value;
    logic signed [wpsd_pkg::SAMPLE_W-1:0] i_sample_value;
    logic [wpsd_pkg::BIN_W-1:0] o_bin_index;
    logic [wpsd_pkg::POWER_W-1:0] o_power;
    logic o_no_segments, o_last_bin;
    logic i_cfg_valid, o_cfg_ready;
    logic [wpsd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [wpsd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    welch_psd_estimator u_top (.*);

    // Stimulus and expectation stores
    t_req pend_reqs[$];
    t_bin bins_due[$];
    int   errors = 0, bins_seen = 0, segs_done = 0, finishes = 0;
    bit   req_taken = 0, cfg_taken = 0;
    int   hold_reqs = 0, hold_done = 0;

    // Spectrum model state
    logic                         m_overlap;
    logic [wpsd_pkg::SCALE_W-1:0] m_scale;
    logic [wpsd_pkg::COEF_W-1:0]  m_win[NSEG];
    int                           m_ring[NSEG];
    longint unsigned              m_acc[NBIN];
    int unsigned                  m_segs, m_seen, m_hop;

    function automatic longint twiddle(int unsigned m);
        m = m & 63;
        if (m <= 16) return wpsd_pkg::QUARTER_COS[m];
        if (m <= 32) return -wpsd_pkg::QUARTER_COS[32 - m];
        if (m <= 48) return -wpsd_pkg::QUARTER_COS[m - 32];
        return wpsd_pkg::QUARTER_COS[64 - m];
    endfunction

    // Round half away from zero
    function automatic longint rnd_shift(longint v, int sh);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint unsigned scaled_bin(longint unsigned avg, int s);
        longint unsigned lo, hi, r;
        lo = (avg & 64'hFFFF_FFFF) * longint'(m_scale);
        hi = (avg >> 32) * longint'(m_scale);
        if (hi >= (64'd1 << (16 + s))) return P_MAX;
        r = (hi << (32 - s)) + (lo >> s);
        return r > P_MAX ? P_MAX : r;
    endfunction

    // Detrend, window, DFT and accumulate one segment
    task automatic fold_segment();
        longint y[NSEG];
        longint sum, re, im;
        longint unsigned mag, a;
        sum = 0;
        for (int i = 0; i < NSEG; i++) sum += m_ring[i];
        for (int i = 0; i < NSEG; i++)
            y[i] = rnd_shift((NSEG * longint'(m_ring[i]) - sum) * longint'(m_win[i]),
                             $clog2(NSEG) + 7);
        for (int k = 0; k < NBIN; k++) begin
            re = 0;
            im = 0;
            for (int i = 0; i < NSEG; i++) begin
                re += y[i] * twiddle(i * k);
                im += y[i] * twiddle(i * k + 48);
            end
            re = rnd_shift(re, 19);
            im = rnd_shift(im, 19);
            mag = longint'(re * re) + longint'(im * im);
            a = m_acc[k] + mag;
            m_acc[k] = a < mag ? 64'hFFFF_FFFF_FFFF_FFFF : a;
        end
        if (m_segs < 24'hFFFFFF) m_segs++;
        segs_done++;
    endtask

    task automatic advance_psd(t_req r);
        t_bin b;
        longint unsigned avg;
        case (r.kind)
            wpsd_pkg::KIND_COEF: m_win[r.idx] = r.coef;
            wpsd_pkg::KIND_SAMPLE: begin
                for (int i = 0; i < NSEG - 1; i++) m_ring[i] = m_ring[i + 1];
                m_ring[NSEG - 1] = r.smp;
                if (m_seen < NSEG) m_seen++;
                if (m_hop < NSEG) m_hop++;
                if (m_seen == NSEG && m_hop >= (m_overlap ? NSEG / 2 : NSEG)) begin
                    fold_segment();
                    m_hop = 0;
                end
            end
            wpsd_pkg::KIND_FINISH: begin
                for (int k = 0; k < NBIN; k++) begin
                    b.bin = wpsd_pkg::BIN_W'(k);
                    b.power = '0;
                    if (m_segs != 0) begin
                        avg = m_acc[k] / longint'(m_segs);
                        b.power = wpsd_pkg::POWER_W'(
                            scaled_bin(avg, (k == 0 || k == NBIN - 1) ? 16 : 15));
                    end
                    b.noseg = m_segs == 0;
                    b.last = k == NBIN - 1;
                    bins_due.push_back(b);
                    m_acc[k] = 0;
                end
                m_segs = 0;
                m_seen = 0;
                m_hop = 0;
                finishes++;
            end
            default: ;
        endcase
    endtask

    // Clock and reset
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Request acceptance and config capture at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            advance_psd(pend_reqs.pop_front());
            req_taken = 1;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == wpsd_pkg::CFG_OVERLAP_HALF) m_overlap = i_cfg_data[0];
            else m_scale = i_cfg_data;
            cfg_taken = 1;
        end
    end

    // Driver: bursts of requests with random gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_valid || req_taken) begin
            req_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 0;
            end else if (pend_reqs.size() > 0) begin
                i_valid <= 1;
                i_kind <= pend_reqs[0].kind;
                i_coef_index <= pend_reqs[0].idx;
                i_coef_value <= pend_reqs[0].coef;
                i_sample_value <= pend_reqs[0].smp;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Receiver stall: pattern with changing density, plus one long hold-off
    int stall_pct = 0, rx_cyc = 0, hold_left = 0;
    always @(negedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 64 == 0) stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
        if (hold_left == 0 && hold_reqs != hold_done && o_valid) begin
            hold_done++;
            hold_left = 4000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1;
        end else begin
            i_stall <= $urandom_range(0, 99) < stall_pct;
        end
    end

    // Result checking
    always @(posedge i_clk) begin
        t_bin e;
        if (i_rst_n && o_valid && !i_stall) begin
            bins_seen++;
            if (bins_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected bin %0d power %0d", $time, o_bin_index, o_power);
            end else begin
                e = bins_due.pop_front();
                if (o_bin_index !== e.bin || o_power !== e.power ||
                    o_no_segments !== e.noseg || o_last_bin !== e.last) begin
                    errors++;
                    $display("%0t: bin mismatch exp bin=%0d pw=%0d ns=%0b lb=%0b",
                             $time, e.bin, e.power, e.noseg, e.last);
                    $display("%0t:              got bin=%0d pw=%0d ns=%0b lb=%0b",
                             $time, o_bin_index, o_power, o_no_segments, o_last_bin);
                end
            end
        end
    end

    task automatic put_req(wpsd_pkg::t_kind k, int idx, int coef, int smp);
        t_req r;
        r.kind = k;
        r.idx = wpsd_pkg::COEF_IDX_W'(idx);
        r.coef = wpsd_pkg::COEF_W'(coef);
        r.smp = wpsd_pkg::SAMPLE_W'(smp);
        pend_reqs.push_back(r);
    endtask

    task automatic put_samples(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: put_req(wpsd_pkg::KIND_SAMPLE, 0, 0, $urandom_range(0, 1) ? 32767 : -32768);
                1: put_req(wpsd_pkg::KIND_SAMPLE, 0, 0, int'($urandom_range(0, 200)) - 100);
                default: put_req(wpsd_pkg::KIND_SAMPLE, 0, 0, $urandom_range(0, 65535));
            endcase
            if ($urandom_range(0, 40) == 0)
                put_req(wpsd_pkg::KIND_COEF, $urandom_range(0, NSEG - 1),
                        $urandom_range(0, 32768), 0);
            if ($urandom_range(0, 50) == 0) put_req(wpsd_pkg::KIND_NONE, $urandom_range(0, 63),
                                                   $urandom_range(0, 65535), 0);
        end
    endtask

    // Wait until all requests are in and all bins are out, then let the block settle
    task automatic settle();
        wait (pend_reqs.size() == 0 && bins_due.size() == 0);
        repeat (2600) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [wpsd_pkg::CFG_IDX_W-1:0] idx,
                             logic [wpsd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_taken = 0;
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 0;
    endtask

    // Phases of stimulus
    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_kind = wpsd_pkg::KIND_NONE;
        i_coef_index = 0;
        i_coef_value = 0;
        i_sample_value = 0;
        i_cfg_valid = 0;
        i_cfg_index = wpsd_pkg::CFG_OVERLAP_HALF;
        i_cfg_data = 0;
        m_overlap = wpsd_pkg::RST_OVERLAP_HALF;
        m_scale = wpsd_pkg::RST_DENSITY_SCALE;
        m_segs = 0;
        m_seen = 0;
        m_hop = 0;
        foreach (m_acc[k]) m_acc[k] = 0;
        foreach (m_ring[i]) m_ring[i] = 0;
        foreach (m_win[i]) m_win[i] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: full window table, empty finish, ignored kind, extreme samples
        write_cfg(wpsd_pkg::CFG_OVERLAP_HALF, 1);
        write_cfg(wpsd_pkg::CFG_DENSITY_SCALE, 65536);
        for (int i = 0; i < NSEG; i++)
            put_req(wpsd_pkg::KIND_COEF, i, i == 0 ? 0 : i == 1 ? 32768 : i == 2 ? 32767
                                                   : $urandom_range(0, 32768), 0);
        put_req(wpsd_pkg::KIND_FINISH, 0, 0, 0);
        put_req(wpsd_pkg::KIND_NONE, 63, 16'hFFFF, -1);
        for (int i = 0; i < NSEG + 4; i++)
            put_req(wpsd_pkg::KIND_SAMPLE, 0, 0, (i % 4 == 0) ? -32768 : (i % 4 == 1) ? 32767
                                                 : (i % 4 == 2) ? 0 : -1);
        put_req(wpsd_pkg::KIND_FINISH, 0, 0, 0);
        // Long output hold-off while more requests wait behind the finish
        hold_reqs++;
        put_samples(12);
        put_req(wpsd_pkg::KIND_FINISH, 0, 0, 0);
        settle();

        // Periodogram with saturating scale, then hop switched mid-stream
        write_cfg(wpsd_pkg::CFG_OVERLAP_HALF, 0);
        write_cfg(wpsd_pkg::CFG_DENSITY_SCALE, 32'hFFFF_FFFF);
        put_samples(66);
        settle();
        write_cfg(wpsd_pkg::CFG_OVERLAP_HALF, 1);
        put_samples(36);
        put_req(wpsd_pkg::KIND_FINISH, 0, 0, 0);
        settle();

        // Zero scale
        write_cfg(wpsd_pkg::CFG_DENSITY_SCALE, 0);
        put_samples(10);
        put_req(wpsd_pkg::KIND_FINISH, 0, 0, 0);
        settle();

        // Random scale, Welch overlap
        write_cfg(wpsd_pkg::CFG_DENSITY_SCALE, $urandom());
        for (int p = 0; p < 3; p++) begin
            put_samples($urandom_range(2, 8));
            put_req(wpsd_pkg::KIND_FINISH, 0, 0, 0);
        end
        settle();

        $display("Covered %0d segments over %0d spectra, %0d bins checked.",
                 segs_done, finishes, bins_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("Timeout with %0d requests and %0d bins pending", pend_reqs.size(),
                 bins_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

[welch_psd_estimator.f]
src/wpsd_pkg.sv
src/wpsd_div.sv
src/welch_psd_estimator.sv
src/wpsd_checker.sv
test/welch_psd_estimator_test.sv
